// ===== hw/rtl/tsps_pkg.sv =====
// ----------------------------------------------------------------------------
// tsps_pkg
// Shared types and constants of the temperature sensor poll sequencer.
// ----------------------------------------------------------------------------
package tsps_pkg;

	// configuration register indexes
	localparam logic [1:0] CFG_WAIT_LIMIT  = 2'd0;
	localparam logic [1:0] CFG_RETRY_LIMIT = 2'd1;
	localparam logic [1:0] CFG_SENSOR_ADDR = 2'd2;

	// configuration reset values
	localparam logic [15:0] WAIT_LIMIT_RST  = 16'd15000;
	localparam logic [3:0]  RETRY_LIMIT_RST = 4'd3;
	localparam logic [6:0]  SENSOR_ADDR_RST = 7'h48;

	// saturation point of the busy poll counter
	localparam logic [15:0] WAIT_COUNT_MAX = 16'hFFFF;

	// issue codes on the result
	localparam logic [1:0] ISSUE_NONE    = 2'd0;
	localparam logic [1:0] ISSUE_POINTER = 2'd1;
	localparam logic [1:0] ISSUE_READ    = 2'd2;

	// phase codes on the result
	localparam logic [1:0] PHASE_IDLE    = 2'd0;
	localparam logic [1:0] PHASE_RETRY   = 2'd1;
	localparam logic [1:0] PHASE_POINTER = 2'd2;
	localparam logic [1:0] PHASE_READ    = 2'd3;

	// request status
	typedef enum logic [3:0] {
		ST_IDLE    = 4'b0001,
		ST_PENDING = 4'b0010,
		ST_DONE    = 4'b0100,
		ST_FAILED  = 4'b1000
	} req_state_t;

	// bus sequence phase
	typedef enum logic [3:0] {
		PH_IDLE    = 4'b0001,
		PH_RETRY   = 4'b0010,
		PH_POINTER = 4'b0100,
		PH_READ    = 4'b1000
	} seq_phase_t;

	// one input item
	typedef struct packed {
		logic       cmd;
		logic       bus_busy;
		logic       bus_ok;
		logic [7:0] data_msb;
		logic [7:0] data_lsb;
	} item_t;

	// one result item
	typedef struct packed {
		logic [1:0]  phase;
		logic [1:0]  issue;
		logic [6:0]  target_address;
		logic        bus_reset;
		logic        reply_ready;
		logic        reply_failed;
		logic [11:0] temperature_tenths;
	} result_t;

	// configuration write
	typedef struct packed {
		logic        we;
		logic [1:0]  index;
		logic [15:0] data;
	} cfg_wr_t;

	// tenths digit of the fraction: floor(frac * 313 / 1000)
	function automatic logic [3:0] frac_tenths(input logic [4:0] frac);
		logic [3:0] t;
		case (frac) inside
			[5'd0:5'd3]:   t = 4'd0;
			[5'd4:5'd6]:   t = 4'd1;
			[5'd7:5'd9]:   t = 4'd2;
			[5'd10:5'd12]: t = 4'd3;
			[5'd13:5'd15]: t = 4'd4;
			[5'd16:5'd19]: t = 4'd5;
			[5'd20:5'd22]: t = 4'd6;
			[5'd23:5'd25]: t = 4'd7;
			[5'd26:5'd28]: t = 4'd8;
			default:       t = 4'd9;
		endcase
		return t;
	endfunction

	// phase code of a one-hot phase
	function automatic logic [1:0] phase_code(input seq_phase_t ph);
		logic [1:0] c;
		case (ph)
			PH_IDLE:    c = PHASE_IDLE;
			PH_RETRY:   c = PHASE_RETRY;
			PH_POINTER: c = PHASE_POINTER;
			PH_READ:    c = PHASE_READ;
			default:    c = PHASE_IDLE;
		endcase
		return c;
	endfunction

endpackage

// ===== hw/rtl/temp_sensor_poll_sequencer.sv =====
// ----------------------------------------------------------------------------
// temp_sensor_poll_sequencer
// Read sequencer for a bus temperature sensor: request/collect and poll items.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid/in_ready): one item per transfer. cmd=1 requests a
//   reading or collects a finished one; cmd=0 polls the bus sequence once with
//   the bus status and the received bytes.
//   Output channel (out_valid/out_ready): exactly one result per item, in order.
//   Configuration: cfg_we with cfg_index/cfg_data writes wait_limit (0),
//   retry_limit (1) or sensor_address (2); write only when idle.
// Timing
//   An item goes to an input register, is processed in one pass against the
//   sequencer state and lands in the result register, which shows its result.
//   One item per cycle is sustained while out_ready is high; the state
//   update of one item is done before the next item is processed.
// Reset and stall
//   Reset clears both registers' valid flags, the request status, phase and
//   counters, and loads the configuration defaults. When the receiver stalls,
//   the result is held and one more item waits in the input register, then
//   in_ready drops until the result is taken.
// ----------------------------------------------------------------------------
module temp_sensor_poll_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// input channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        cmd,
	input  logic        bus_busy,
	input  logic        bus_ok,
	input  logic [7:0]  data_msb,
	input  logic [7:0]  data_lsb,
	// output channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  phase,
	output logic [1:0]  issue,
	output logic [6:0]  target_address,
	output logic        bus_reset,
	output logic        reply_ready,
	output logic        reply_failed,
	output logic [11:0] temperature_tenths
);

	logic              valid_s1;
	tsps_pkg::item_t   item_s1;
	logic              advance;
	tsps_pkg::cfg_wr_t cfg;
	tsps_pkg::result_t result;
	tsps_pkg::result_t result_q;

	// stage handshake
	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= '{cmd: cmd, bus_busy: bus_busy, bus_ok: bus_ok,
				data_msb: data_msb, data_lsb: data_lsb};
		end
	end

	assign cfg = '{we: cfg_we, index: cfg_index, data: cfg_data};

	// sequencer
	tsps_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.step   (advance),
		.item   (item_s1),
		.result (result)
	);

	// result register
	tsps_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.result_in (result),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.result_q  (result_q)
	);

	assign phase              = result_q.phase;
	assign issue              = result_q.issue;
	assign target_address     = result_q.target_address;
	assign bus_reset          = result_q.bus_reset;
	assign reply_ready        = result_q.reply_ready;
	assign reply_failed       = result_q.reply_failed;
	assign temperature_tenths = result_q.temperature_tenths;

endmodule

// ===== hw/rtl/tsps_seq.sv =====
// ----------------------------------------------------------------------------
// tsps_seq
// Sequencer state, configuration registers and the single-pass update that
// turns one registered item into its result.
// ----------------------------------------------------------------------------
module tsps_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  tsps_pkg::cfg_wr_t cfg,
	input  logic              step,
	input  tsps_pkg::item_t   item,
	output tsps_pkg::result_t result
);

	logic [15:0] wait_limit_q;
	logic [3:0]  retry_limit_q;
	logic [6:0]  sensor_addr_q;

	tsps_pkg::req_state_t st_q, st_d;
	tsps_pkg::seq_phase_t ph_q, ph_d;
	logic [15:0] wait_count_q, wait_count_d;
	logic [3:0]  error_count_q, error_count_d;
	logic [7:0]  temp_int_q;
	logic [4:0]  temp_frac_q;
	logic        load_temp;

	logic [15:0] wait_sat;
	logic [4:0]  error_next;
	logic        fault_hit;
	logic [1:0]  issue;
	logic        ready;
	logic        failed;
	logic [11:0] tenths;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wait_limit_q  <= tsps_pkg::WAIT_LIMIT_RST;
			retry_limit_q <= tsps_pkg::RETRY_LIMIT_RST;
			sensor_addr_q <= tsps_pkg::SENSOR_ADDR_RST;
		end else if (cfg.we) begin
			case (cfg.index)
				tsps_pkg::CFG_WAIT_LIMIT:  wait_limit_q  <= cfg.data;
				tsps_pkg::CFG_RETRY_LIMIT: retry_limit_q <= cfg.data[3:0];
				tsps_pkg::CFG_SENSOR_ADDR: sensor_addr_q <= cfg.data[6:0];
				default: ;
			endcase
		end
	end

	// saturating busy count and next error count
	assign wait_sat   = (wait_count_q != tsps_pkg::WAIT_COUNT_MAX) ?
		wait_count_q + 16'd1 : wait_count_q;
	assign error_next = {1'b0, error_count_q} + 5'd1;

	// next state and result of the item
	always_comb begin
		st_d          = st_q;
		ph_d          = ph_q;
		wait_count_d  = wait_count_q;
		error_count_d = error_count_q;
		load_temp     = 1'b0;
		fault_hit     = 1'b0;
		issue         = tsps_pkg::ISSUE_NONE;
		ready         = 1'b0;
		failed        = 1'b0;
		tenths        = '0;

		if (item.cmd) begin
			// request or collect
			case (st_q)
				tsps_pkg::ST_IDLE: st_d = tsps_pkg::ST_PENDING;
				tsps_pkg::ST_DONE: begin
					st_d   = tsps_pkg::ST_IDLE;
					ready  = 1'b1;
					tenths = {1'b0, temp_int_q, 3'b000} + {3'b000, temp_int_q, 1'b0}
						+ {8'd0, tsps_pkg::frac_tenths(temp_frac_q)};
				end
				tsps_pkg::ST_FAILED: begin
					st_d   = tsps_pkg::ST_IDLE;
					ready  = 1'b1;
					failed = 1'b1;
				end
				default: ;
			endcase
		end else begin
			// one poll of the bus sequence
			case (ph_q)
				tsps_pkg::PH_IDLE, tsps_pkg::PH_RETRY: begin
					wait_count_d = '0;
					if (st_q == tsps_pkg::ST_PENDING) begin
						issue = tsps_pkg::ISSUE_POINTER;
						ph_d  = tsps_pkg::PH_POINTER;
					end
				end
				tsps_pkg::PH_POINTER, tsps_pkg::PH_READ: begin
					if (item.bus_busy) begin
						wait_count_d = wait_sat;
						fault_hit    = (wait_sat > wait_limit_q);
					end else if (item.bus_ok) begin
						error_count_d = '0;
						if (ph_q == tsps_pkg::PH_POINTER) begin
							issue = tsps_pkg::ISSUE_READ;
							ph_d  = tsps_pkg::PH_READ;
						end else begin
							load_temp = 1'b1;
							ph_d      = tsps_pkg::PH_IDLE;
							if (st_q == tsps_pkg::ST_PENDING)
								st_d = tsps_pkg::ST_DONE;
						end
					end else begin
						fault_hit = 1'b1;
					end
				end
				default: ;
			endcase

			// fault: retry from idle or give up
			if (fault_hit) begin
				if (error_next > {1'b0, retry_limit_q}) begin
					if (st_q == tsps_pkg::ST_PENDING)
						st_d = tsps_pkg::ST_FAILED;
					ph_d          = tsps_pkg::PH_IDLE;
					error_count_d = '0;
				end else begin
					error_count_d = error_next[3:0];
					ph_d          = tsps_pkg::PH_RETRY;
				end
			end
		end

		result.phase              = tsps_pkg::phase_code(ph_d);
		result.issue              = issue;
		result.target_address     = (issue != tsps_pkg::ISSUE_NONE) ? sensor_addr_q : '0;
		result.bus_reset          = fault_hit;
		result.reply_ready        = ready;
		result.reply_failed       = failed;
		result.temperature_tenths = tenths;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q          <= tsps_pkg::ST_IDLE;
			ph_q          <= tsps_pkg::PH_IDLE;
			wait_count_q  <= '0;
			error_count_q <= '0;
		end else if (step) begin
			st_q          <= st_d;
			ph_q          <= ph_d;
			wait_count_q  <= wait_count_d;
			error_count_q <= error_count_d;
		end
	end

	// last reading, integer and fraction of the 13-bit word
	always_ff @(posedge clk) begin
		if (step && load_temp) begin
			temp_int_q  <= item.data_msb;
			temp_frac_q <= item.data_lsb[7:3];
		end
	end

endmodule

// ===== hw/rtl/tsps_out_stage.sv =====
// ----------------------------------------------------------------------------
// tsps_out_stage
// Result register that holds a finished result until the receiver takes it.
// ----------------------------------------------------------------------------
module tsps_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  tsps_pkg::result_t result_in,
	input  logic              out_ready,
	output logic              out_valid,
	output tsps_pkg::result_t result_q
);

	logic out_valid_q;

	assign out_valid = out_valid_q;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load)
			result_q <= result_in;
	end

endmodule

// ===== hw/rtl/tsps_checker.sv =====
// ----------------------------------------------------------------------------
// tsps_checker
// Port-level checks of the sequencer results, bound to the top level.
// ----------------------------------------------------------------------------
module tsps_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  phase,
	input logic [1:0]  issue,
	input logic [6:0]  target_address,
	input logic        bus_reset,
	input logic        reply_ready,
	input logic        reply_failed,
	input logic [11:0] temperature_tenths
);

	// stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(phase) && $stable(issue)
			&& $stable(reply_ready) && $stable(temperature_tenths))
		else $error("result changed while stalled");

	// a poll result that issues a transfer or a bus reset never carries a reply
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (issue != tsps_pkg::ISSUE_NONE || bus_reset)
			|-> !reply_ready && !reply_failed && temperature_tenths == 12'd0)
		else $error("reply fields on a poll result");

	// a failed reply carries no temperature
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && reply_failed |-> reply_ready && temperature_tenths == 12'd0)
		else $error("inconsistent failed reply");

	// an issued transfer agrees with the phase, and no address without one
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (issue == tsps_pkg::ISSUE_NONE && target_address == 7'd0)
			|| (issue == tsps_pkg::ISSUE_POINTER && phase == tsps_pkg::PHASE_POINTER)
			|| (issue == tsps_pkg::ISSUE_READ && phase == tsps_pkg::PHASE_READ))
		else $error("issue does not match phase");

endmodule

bind temp_sensor_poll_sequencer tsps_checker u_tsps_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.out_valid          (out_valid),
	.out_ready          (out_ready),
	.phase              (phase),
	.issue              (issue),
	.target_address     (target_address),
	.bus_reset          (bus_reset),
	.reply_ready        (reply_ready),
	.reply_failed       (reply_failed),
	.temperature_tenths (temperature_tenths)
);
